// ===== hw/rtl/srcc_pkg.sv =====
// Shared constants, codes and the CRC-8 helper for the sensor response checker.
// No dependencies; the scaler, the core and the bench import this package.
package srcc_pkg;

    // CRC-8: polynomial x^8 + x^5 + x^4 + 1, preset to all ones, no reflection.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Response kinds held in the configuration register.
    localparam logic [1:0] RESP_MEAS   = 2'd0;
    localparam logic [1:0] RESP_STATUS = 2'd1;
    localparam logic [1:0] RESP_SERIAL = 2'd2;

    // Kinds of converted reading carried with a result word.
    localparam logic [1:0] VK_NONE = 2'd0;
    localparam logic [1:0] VK_TEMP = 2'd1;
    localparam logic [1:0] VK_HUM  = 2'd2;

    // Position of a byte inside its triplet.
    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_CRC  = 2'd2;

    // Configuration bus geometry and register index.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_RESPONSE_KIND = 1'b0;

    // Conversion constants: reading = floor(coef * raw / 65535) - offset.
    localparam logic [14:0] TEMP_COEF   = 15'd17500;
    localparam logic [14:0] HUM_COEF    = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // Converted reading handed from the scaler to the result register.
    typedef struct packed {
        logic signed [14:0] scaled_value;
        logic [1:0]         value_kind;
    } scale_out_t;

    // One byte of the CRC-8, shifted through MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/srcc_in_if.sv =====
// Byte channel into the sensor response checker: valid/ready plus one byte and a frame-start flag.
// No dependencies.
interface srcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== hw/rtl/srcc_out_if.sv =====
// Result channel out of the sensor response checker: valid/ready plus one word.
// No dependencies.
interface srcc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        word_value;
    logic               crc_match;
    logic               frame_ok;
    logic signed [14:0] scaled_value;
    logic [1:0]         value_kind;
    logic [31:0]        serial_number;
    logic               frame_end;

    modport source (output valid, output word_value, output crc_match, output frame_ok,
                    output scaled_value, output value_kind, output serial_number,
                    output frame_end, input ready);
    modport sink   (input valid, input word_value, input crc_match, input frame_ok,
                    input scaled_value, input value_kind, input serial_number,
                    input frame_end, output ready);
endinterface

// ===== hw/rtl/srcc_scale.sv =====
// Converts a raw 16-bit sensor word to centidegrees or centipercent.
// Depends on srcc_pkg for the conversion constants and the output struct.
module srcc_scale (
    input  logic [15:0]               raw_word,
    input  logic                      measure,
    input  logic                      second,
    output srcc_pkg::scale_out_t      result
);
    import srcc_pkg::*;

    logic [14:0] coef;
    logic [30:0] product;
    logic [14:0] prod_hi;
    logic [16:0] fold_sum;
    logic [14:0] quotient;
    logic [14:0] offset;

    // One constant-coefficient multiply; humidity on the second word.
    assign coef    = second ? HUM_COEF : TEMP_COEF;
    assign product = 31'(coef) * 31'(raw_word);

    // Divide by 2^16-1: x = a*65536 + b gives a plus one when a + b reaches 65535.
    assign prod_hi  = product[30:16];
    assign fold_sum = 17'(prod_hi) + 17'(product[15:0]);
    assign quotient = prod_hi + 15'(fold_sum >= FULL_SCALE);

    // Temperature carries a fixed offset; the result wraps into 15 bits.
    assign offset = second ? 15'd0 : TEMP_OFFSET;

    always_comb
    begin
        if (measure)
        begin
            result.scaled_value = $signed(quotient - offset);
            result.value_kind   = second ? VK_HUM : VK_TEMP;
        end
        else
        begin
            result.scaled_value = '0;
            result.value_kind   = VK_NONE;
        end
    end

endmodule

// ===== hw/rtl/sensor_response_crc_checker_core.sv =====
// Top level of the sensor response checker: byte input stage, frame tracking,
// CRC check, result register and configuration port.
// Depends on srcc_pkg, srcc_in_if, srcc_out_if and srcc_scale.
//
// Usage: response bytes enter on the rx channel one byte at a time, with
// frame_start set on the first byte of a frame. Bytes group into triplets of
// a big-endian word and its CRC-8; each finished triplet produces one word on
// the result channel, other bytes produce nothing. The response kind
// (measurement, status, serial number) is set through the APB port at byte
// address 0; reads return it. The user must write it only while the block
// is idle; the block itself does not enforce this. After a triplet's CRC byte
// is accepted, its result passes the input and then the result register.
// Throughput: one byte per cycle when not stalled; the CRC byte update and
// the conversion multiply sit in the single stage between the two registers.
// When the receiver stalls, the result is held and one more byte can wait
// in the input register; rx.ready drops only when both are full.
// Reset empties both registers, clears the register to measurement mode and
// starts a new frame with the CRC preset to all ones.
module sensor_response_crc_checker_core (
    input  logic                               clk,
    input  logic                               rst_n,
    srcc_in_if.sink                            rx,
    srcc_out_if.source                         result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [srcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [srcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import srcc_pkg::*;

    // Configuration register.
    logic [1:0]  kind_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // Frame state.
    logic [7:0]  crc_reg, crc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        tidx_reg, tidx_next;
    logic        err_reg, err_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] first_word_reg, first_word_next;

    // Result register.
    logic               out_valid_reg;
    logic [15:0]        word_reg;
    logic               match_reg;
    logic               ok_reg;
    logic signed [14:0] scaled_reg;
    logic [1:0]         vkind_reg;
    logic [31:0]        serial_reg;
    logic               end_reg;

    // Stage signals.
    logic        out_free;
    logic        stage_go;
    logic        has_result;
    logic [7:0]  eff_crc;
    logic [1:0]  eff_pos;
    logic        eff_tidx;
    logic        eff_err;
    logic        two_triplets;
    logic [15:0] word;
    logic        match;
    logic        last;
    logic [31:0] serial;
    scale_out_t  conv;

    // APB: always ready, one register at index 0.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESPONSE_KIND) ? APB_DATA_W'(kind_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= RESP_MEAS;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_RESPONSE_KIND))
        begin
            kind_reg <= pwdata[1:0];
        end
    end

    // Handshake: the stage moves when its byte makes no result or the result slot frees.
    assign out_free = !out_valid_reg || result.ready;
    assign stage_go = in_valid_reg && (!has_result || out_free);
    assign rx.ready = !in_valid_reg || stage_go;

    // A frame start discards any partial frame before this byte is used.
    assign eff_crc  = in_start_reg ? CRC_INIT : crc_reg;
    assign eff_pos  = in_start_reg ? POS_HIGH : pos_reg;
    assign eff_tidx = in_start_reg ? 1'b0 : tidx_reg;
    assign eff_err  = in_start_reg ? 1'b0 : err_reg;

    assign has_result   = (eff_pos != POS_HIGH) && (eff_pos != POS_LOW);
    assign two_triplets = (kind_reg == RESP_MEAS) || (kind_reg == RESP_SERIAL);
    assign word         = {high_reg, low_reg};
    assign match        = (in_byte_reg == eff_crc);
    assign last         = !two_triplets || eff_tidx;
    assign serial       = ((kind_reg == RESP_SERIAL) && eff_tidx) ? {first_word_reg, word} : '0;

    srcc_scale u_scale (
        .raw_word (word),
        .measure  (kind_reg == RESP_MEAS),
        .second   (eff_tidx),
        .result   (conv)
    );

    // Next frame state for the byte in the input register.
    always_comb
    begin
        crc_next        = eff_crc;
        pos_next        = eff_pos;
        tidx_next       = eff_tidx;
        err_next        = eff_err;
        high_next       = high_reg;
        low_next        = low_reg;
        first_word_next = first_word_reg;
        case (eff_pos)
            POS_HIGH:
            begin
                high_next = in_byte_reg;
                crc_next  = crc8_update(eff_crc, in_byte_reg);
                pos_next  = POS_LOW;
            end
            POS_LOW:
            begin
                low_next = in_byte_reg;
                crc_next = crc8_update(eff_crc, in_byte_reg);
                pos_next = POS_CRC;
            end
            default:
            begin
                crc_next = CRC_INIT;
                pos_next = POS_HIGH;
                if (!eff_tidx)
                begin
                    first_word_next = word;
                end
                if (last)
                begin
                    tidx_next = 1'b0;
                    err_next  = 1'b0;
                end
                else
                begin
                    tidx_next = 1'b1;
                    err_next  = eff_err || !match;
                end
            end
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg  <= rx.data_byte;
            in_start_reg <= rx.frame_start;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            pos_reg        <= POS_HIGH;
            tidx_reg       <= 1'b0;
            err_reg        <= 1'b0;
            high_reg       <= '0;
            low_reg        <= '0;
            first_word_reg <= '0;
        end
        else if (stage_go)
        begin
            crc_reg        <= crc_next;
            pos_reg        <= pos_next;
            tidx_reg       <= tidx_next;
            err_reg        <= err_next;
            high_reg       <= high_next;
            low_reg        <= low_next;
            first_word_reg <= first_word_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && has_result)
        begin
            word_reg   <= word;
            match_reg  <= match;
            ok_reg     <= !(eff_err || !match);
            scaled_reg <= conv.scaled_value;
            vkind_reg  <= conv.value_kind;
            serial_reg <= serial;
            end_reg    <= last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.word_value    = word_reg;
    assign result.crc_match     = match_reg;
    assign result.frame_ok      = ok_reg;
    assign result.scaled_value  = scaled_reg;
    assign result.value_kind    = vkind_reg;
    assign result.serial_number = serial_reg;
    assign result.frame_end     = end_reg;

    // A frame cannot be good when the triplet just checked failed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!ok_reg || match_reg))
        else $error("frame_ok set on a triplet whose CRC failed");

    // A converted reading and a serial number never share one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (vkind_reg != VK_NONE)) |-> (serial_reg == '0))
        else $error("serial number given with a converted reading");

    // Temperature is always the first of two triplets, so it never closes a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (vkind_reg == VK_TEMP)) |-> !end_reg)
        else $error("temperature result marked as frame end");

    // The byte position only walks through the three triplet slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_HIGH) || (pos_reg == POS_LOW) || (pos_reg == POS_CRC))
        else $error("byte position left the triplet");

    // A stalled result is never overwritten by the next triplet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(word_reg) && out_valid_reg)
        else $error("held result overwritten");

endmodule

// ===== bench/sensor_response_crc_checker_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sensor_response_crc_checker_core: drives response bytes,
// predicts every triplet word and checks the result channel and the APB register.
// Depends on srcc_pkg, srcc_in_if, srcc_out_if and the core itself.
module sensor_response_crc_checker_core_test;
    import srcc_pkg::*;

    // Unused response kind, treated by the block like a status response.
    localparam logic [1:0] RESP_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] KIND_ADDR = {REG_RESPONSE_KIND, 2'b00};

    // One result word as the block should present it.
    typedef struct packed {
        logic [15:0] word;
        logic        crc_ok;
        logic        frame_ok;
        logic [14:0] scaled;
        logic [1:0]  kind;
        logic [31:0] serial;
        logic        tail;
    } triplet_word_t;

    // Tracks the frame state of the sensor response and holds the words still due.
    class frame_tracker;
        logic [1:0]    kind_reg;
        logic [7:0]    crc_acc;
        logic [1:0]    pos;
        logic          second_triplet;
        logic          frame_bad;
        logic [7:0]    hi_byte;
        logic [7:0]    lo_byte;
        logic [15:0]   word0;
        triplet_word_t pending_words[$];
        int            fault_count;

        function new();
            kind_reg = RESP_MEAS;
            hi_byte = 8'h00;
            lo_byte = 8'h00;
            word0 = 16'h0000;
            fault_count = 0;
            restart();
        endfunction

        static function logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ b[i];
                c = {c[6:0], 1'b0};
                if (fb)
                begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void restart();
            crc_acc = CRC_INIT;
            pos = POS_HIGH;
            second_triplet = 1'b0;
            frame_bad = 1'b0;
        endfunction

        function void set_kind(input logic [31:0] value);
            kind_reg = value[1:0];
        endfunction

        function void flag(input string msg);
            fault_count++;
            if (fault_count <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        // Advance the frame state by one accepted byte.
        function void take_byte(input logic [7:0] b, input logic start);
            triplet_word_t r;
            logic          two;
            logic [31:0]   t;
            if (start)
            begin
                restart();
            end
            if (pos == POS_HIGH)
            begin
                hi_byte = b;
                crc_acc = crc8_next(crc_acc, b);
                pos = POS_LOW;
                return;
            end
            if (pos == POS_LOW)
            begin
                lo_byte = b;
                crc_acc = crc8_next(crc_acc, b);
                pos = POS_CRC;
                return;
            end

            // CRC byte: the triplet is finished.
            two = (kind_reg == RESP_MEAS) || (kind_reg == RESP_SERIAL);
            r.word = {hi_byte, lo_byte};
            r.crc_ok = (b == crc_acc);
            if (!r.crc_ok)
            begin
                frame_bad = 1'b1;
            end
            r.frame_ok = !frame_bad;
            r.tail = !two || second_triplet;
            r.scaled = 15'd0;
            r.kind = VK_NONE;
            r.serial = 32'd0;
            if (kind_reg == RESP_MEAS)
            begin
                if (!second_triplet)
                begin
                    t = (32'd17500 * {16'd0, r.word}) / 32'd65535;
                    t = t - 32'd4500;
                    r.kind = VK_TEMP;
                end
                else
                begin
                    t = (32'd10000 * {16'd0, r.word}) / 32'd65535;
                    r.kind = VK_HUM;
                end
                r.scaled = t[14:0];
            end
            if (kind_reg == RESP_SERIAL && second_triplet)
            begin
                r.serial = {word0, r.word};
            end
            if (!second_triplet)
            begin
                word0 = r.word;
            end
            pending_words.push_back(r);

            crc_acc = CRC_INIT;
            pos = POS_HIGH;
            if (r.tail)
            begin
                restart();
            end
            else
            begin
                second_triplet = 1'b1;
            end
        endfunction

        // Compare one accepted result word with the oldest one due.
        function void match_result(input triplet_word_t got);
            triplet_word_t e;
            if (pending_words.size() == 0)
            begin
                flag($sformatf("%0t: result word 0x%h arrived with none due", $time, got.word));
                return;
            end
            e = pending_words.pop_front();
            if (got.word !== e.word || got.crc_ok !== e.crc_ok || got.frame_ok !== e.frame_ok
                || got.scaled !== e.scaled || got.kind !== e.kind
                || got.serial !== e.serial || got.tail !== e.tail)
            begin
                flag($sformatf({"%0t: mismatch, expected word=%h crc=%b ok=%b scaled=%0d ",
                                "kind=%0d serial=%h end=%b, got word=%h crc=%b ok=%b ",
                                "scaled=%0d kind=%0d serial=%h end=%b"}, $time,
                               e.word, e.crc_ok, e.frame_ok, $signed(e.scaled), e.kind,
                               e.serial, e.tail, got.word, got.crc_ok, got.frame_ok,
                               $signed(got.scaled), got.kind, got.serial, got.tail));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    srcc_in_if  rx_if ();
    srcc_out_if res_if ();

    sensor_response_crc_checker_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_tracker tracker;
    int           send_idle_pct = 7;
    int           recv_idle_pct = 68;
    int           bytes_sent = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, with a long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready = 1'b0;
        end
        else
        begin
            res_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result word taken by the bench.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            tracker.match_result('{res_if.word_value, res_if.crc_match, res_if.frame_ok,
                                   res_if.scaled_value, res_if.value_kind,
                                   res_if.serial_number, res_if.frame_end});
        end
    end

    // Offer one byte, with random gaps before it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_if.valid = 1'b0;
            @(negedge clk);
        end
        rx_if.valid = 1'b1;
        rx_if.data_byte = b;
        rx_if.frame_start = start;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        tracker.take_byte(b, start);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_triplet(input logic [15:0] w, input logic start, input logic good);
        logic [7:0] c;
        c = frame_tracker::crc8_next(frame_tracker::crc8_next(CRC_INIT, w[15:8]), w[7:0]);
        if (!good)
        begin
            c = c ^ 8'h01;
        end
        send_byte(w[15:8], start);
        send_byte(w[7:0], 1'b0);
        send_byte(c, 1'b0);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One frame for the given response kind: mostly well formed, some cut short,
    // some plain noise, a few without the start mark.
    task automatic send_random_frame(input logic [1:0] k);
        logic [7:0]  seq [6];
        logic [15:0] w;
        logic [7:0]  c;
        int          n;
        int          len;
        int          shape;
        logic        mark;
        n = (k == RESP_MEAS || k == RESP_SERIAL) ? 2 : 1;
        mark = ($urandom_range(0, 9) != 0);
        shape = $urandom_range(0, 19);
        if (shape == 1)
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            return;
        end
        c = CRC_INIT;
        for (int t = 0; t < n; t++)
        begin
            w = rand_word();
            c = frame_tracker::crc8_next(frame_tracker::crc8_next(CRC_INIT, w[15:8]), w[7:0]);
            if ($urandom_range(0, 99) < 15)
            begin
                c = ($urandom_range(0, 1) == 0) ? c ^ (8'h01 << $urandom_range(0, 7))
                                                : 8'($urandom);
            end
            seq[3*t]   = w[15:8];
            seq[3*t+1] = w[7:0];
            seq[3*t+2] = c;
        end
        len = (shape == 0) ? $urandom_range(1, 3*n - 1) : 3*n;
        for (int i = 0; i < len; i++)
        begin
            send_byte(seq[i], (i == 0) ? mark : 1'b0);
        end
    endtask

    // Wait until every due word has arrived, then let the input stage empty.
    task automatic wait_drained();
        int guard;
        guard = 0;
        rx_if.valid = 1'b0;
        while (tracker.pending_words.size() != 0 && guard < 50000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    // APB transfer: setup cycle, then access cycle ending at the sampling edge.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        if (wr && addr == KIND_ADDR)
        begin
            tracker.set_kind(wdata);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_response_kind(input logic [1:0] k);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, KIND_ADDR, {{(APB_DATA_W-2){1'b0}}, k}, rd);
        apb_access(1'b0, KIND_ADDR, '0, rd);
        if (rd !== {{(APB_DATA_W-2){1'b0}}, k})
        begin
            tracker.flag($sformatf("%0t: register read expected %0d, got %h", $time, k, rd));
        end
    endtask

    initial
    begin
        logic [1:0] plan [12];
        int         phase_start;

        plan = '{RESP_SERIAL, RESP_STATUS, RESP_MEAS, RESP_UNUSED,
                 RESP_MEAS, RESP_SERIAL, RESP_STATUS, RESP_UNUSED,
                 RESP_SERIAL, RESP_MEAS, RESP_STATUS, RESP_MEAS};
        tracker = new();
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.data_byte = 8'h00;
        rx_if.frame_start = 1'b0;
        res_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, measurement mode after reset: reading extremes, a failed CRC that
        // still converts, a frame begun without a start mark after a finished one,
        // and a start mark in the middle of a triplet.
        send_triplet(16'h0000, 1'b1, 1'b1);
        send_triplet(16'hFFFF, 1'b0, 1'b1);
        send_triplet(16'hFFFF, 1'b1, 1'b1);
        send_triplet(16'h0000, 1'b0, 1'b0);
        send_triplet(16'h8000, 1'b0, 1'b0);
        send_triplet(16'h1234, 1'b0, 1'b1);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hCD, 1'b0);
        send_triplet(16'h6666, 1'b1, 1'b1);
        // The frame is left open here, so the next register write lands mid-frame.

        for (int ph = 0; ph < 12; ph++)
        begin
            // Gaps: sender light and receiver heavy, then the reverse, then none.
            case (ph / 4)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_drained();
            set_response_kind(plan[ph]);
            if (ph == 9)
            begin
                hold_requests++;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 100)
            begin
                send_random_frame(plan[ph]);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                send_triplet(rand_word(), 1'b1, 1'b1);
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (tracker.pending_words.size() != 0)
        begin
            tracker.flag($sformatf("%0d result words never arrived",
                                   tracker.pending_words.size()));
        end
        if (tracker.fault_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
